// ===== hdl/ash_pkg.sv =====
package ash_pkg;

   localparam int SAMPLE_W   = 10;
   localparam int PCT_W      = 7;
   localparam int GROUP_SIZE = 20;
   localparam int COUNT_W    = $clog2(GROUP_SIZE + 1);
   localparam int SUM_W      = SAMPLE_W + $clog2(GROUP_SIZE + 1);
   localparam int NUM_W      = SAMPLE_W + PCT_W;
   localparam int DIV_W      = (NUM_W > SUM_W) ? NUM_W : SUM_W;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
   localparam int CSR_IDX_W  = 2;

   localparam logic [SAMPLE_W-1:0] FAULT_LEVEL     = SAMPLE_W'(10);
   localparam logic [PCT_W-1:0]    SCALE_TOP       = PCT_W'(100);
   localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST   = SAMPLE_W'(0);
   localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RST  = SAMPLE_W'(680);
   localparam logic [SAMPLE_W-1:0] HOLD_BAND_RST   = SAMPLE_W'(20);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE_LOW    = 2'd0,
      CSR_RANGE_HIGH   = 2'd1,
      CSR_HOLD_BAND    = 2'd2,
      CSR_INVERT_SCALE = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG,
      ST_SCALE,
      ST_PCT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                start;
      logic [DIV_W-1:0]    dividend;
      logic [SAMPLE_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_sts_type;

endpackage

// ===== hdl/ash_if.sv =====
interface ash_req_if;
   logic                         valid;
   logic                         ready;
   logic [ash_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface ash_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ash_pkg::PCT_W-1:0]    percent;
   logic [ash_pkg::SAMPLE_W-1:0] held_raw;
   logic                         line_fault;

   modport source (output valid, output percent, output held_raw, output line_fault,
                   input ready);
   modport sink   (input valid, input percent, input held_raw, input line_fault,
                   output ready);
endinterface

// ===== hdl/averaged_sensor_with_hysteresis.sv =====
// A request that does not close a group only adds to the sum and count; the block stays idle.
// The request that closes a group runs the shared divider for the average (17 steps) and then,
// unless the range is empty, again for the percentage (17 steps) before the result is offered.
// After a group closes, no request is taken until the result is taken,
// and ready returns the cycle after the result handshake.
// Synchronous active-high reset clears sum, count, held value and loads register defaults.
module averaged_sensor_with_hysteresis (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [ash_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ash_pkg::SAMPLE_W-1:0]          csr_wdata,
   ash_req_if.sink                               req_if,
   ash_rsp_if.source                             rsp_if
);

   ash_pkg::state_type state_ff, state_in;

   logic [ash_pkg::SAMPLE_W-1:0] range_low_ff, range_high_ff, hold_band_ff;
   logic                         invert_ff;

   logic [ash_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [ash_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [ash_pkg::SAMPLE_W-1:0] last_ff, last_in;
   logic [ash_pkg::PCT_W-1:0]    pct_ff, pct_in;
   logic                         fault_ff, fault_in;

   logic                         req_fire, group_end, range_ok;
   logic [ash_pkg::SAMPLE_W-1:0] avg, diff, clamped, offset, span;
   logic [ash_pkg::DIV_W-1:0]    numer;
   logic [ash_pkg::PCT_W-1:0]    quo_pct;

   ash_pkg::div_ctl_type div_ctl;
   ash_pkg::div_sts_type div_sts;

   ash_divider u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   assign req_fire  = req_if.valid && req_if.ready;
   assign group_end = (count_ff == ash_pkg::COUNT_W'(ash_pkg::GROUP_SIZE - 1));
   assign range_ok  = (range_high_ff > range_low_ff);
   assign span      = range_high_ff - range_low_ff;
   assign sum_in    = sum_ff + ash_pkg::SUM_W'(req_if.sample);

   // average fits the sample width
   assign avg  = div_sts.quotient[ash_pkg::SAMPLE_W-1:0];
   assign diff = (avg >= last_ff) ? (avg - last_ff) : (last_ff - avg);

   always_comb begin
      clamped = last_ff;
      if (clamped < range_low_ff) clamped = range_low_ff;
      if (clamped > range_high_ff) clamped = range_high_ff;
   end
   assign offset  = clamped - range_low_ff;
   assign numer   = ash_pkg::DIV_W'(offset) * ash_pkg::DIV_W'(ash_pkg::SCALE_TOP);
   assign quo_pct = div_sts.quotient[ash_pkg::PCT_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ash_pkg::ST_IDLE:  if (req_fire && group_end) state_in = ash_pkg::ST_AVG;
         ash_pkg::ST_AVG:   if (div_sts.done) state_in = ash_pkg::ST_SCALE;
         ash_pkg::ST_SCALE: state_in = range_ok ? ash_pkg::ST_PCT : ash_pkg::ST_OUT;
         ash_pkg::ST_PCT:   if (div_sts.done) state_in = ash_pkg::ST_OUT;
         ash_pkg::ST_OUT:   if (rsp_if.ready) state_in = ash_pkg::ST_IDLE;
         default:           state_in = ash_pkg::ST_IDLE;
      endcase
   end

   // outputs and divider control
   always_comb begin
      req_if.ready     = 1'b0;
      rsp_if.valid     = 1'b0;
      div_ctl.start    = 1'b0;
      div_ctl.dividend = ash_pkg::DIV_W'(sum_in);
      div_ctl.divisor  = ash_pkg::SAMPLE_W'(ash_pkg::GROUP_SIZE);
      case (state_ff)
         ash_pkg::ST_IDLE: begin
            req_if.ready  = 1'b1;
            div_ctl.start = req_fire && group_end;
         end
         ash_pkg::ST_SCALE: begin
            div_ctl.start    = range_ok;
            div_ctl.dividend = numer;
            div_ctl.divisor  = span;
         end
         ash_pkg::ST_OUT: rsp_if.valid = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      last_in  = last_ff;
      fault_in = fault_ff;
      pct_in   = pct_ff;
      if (state_ff == ash_pkg::ST_IDLE && req_fire) begin
         count_in = group_end ? '0 : count_ff + ash_pkg::COUNT_W'(1);
      end
      if (state_ff == ash_pkg::ST_AVG && div_sts.done) begin
         if (diff > hold_band_ff) last_in = avg;
         fault_in = (last_in <= ash_pkg::FAULT_LEVEL);
      end
      if (state_ff == ash_pkg::ST_SCALE && !range_ok) pct_in = '0;
      if (state_ff == ash_pkg::ST_PCT && div_sts.done) begin
         pct_in = invert_ff ? (ash_pkg::SCALE_TOP - quo_pct) : quo_pct;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ash_pkg::ST_IDLE;
         sum_ff        <= '0;
         count_ff      <= '0;
         last_ff       <= '0;
         fault_ff      <= 1'b0;
         range_low_ff  <= ash_pkg::RANGE_LOW_RST;
         range_high_ff <= ash_pkg::RANGE_HIGH_RST;
         hold_band_ff  <= ash_pkg::HOLD_BAND_RST;
         invert_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         last_ff  <= last_in;
         fault_ff <= fault_in;
         if (state_ff == ash_pkg::ST_IDLE && req_fire) begin
            sum_ff <= group_end ? '0 : sum_in;
         end
         if (csr_we) begin
            case (ash_pkg::csr_index_type'(csr_index))
               ash_pkg::CSR_RANGE_LOW:    range_low_ff  <= csr_wdata;
               ash_pkg::CSR_RANGE_HIGH:   range_high_ff <= csr_wdata;
               ash_pkg::CSR_HOLD_BAND:    hold_band_ff  <= csr_wdata;
               ash_pkg::CSR_INVERT_SCALE: invert_ff     <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      pct_ff <= pct_in;
   end

   assign rsp_if.percent    = pct_ff;
   assign rsp_if.held_raw   = last_ff;
   assign rsp_if.line_fault = fault_ff;

endmodule

// ===== hdl/ash_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module ash_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ash_pkg::div_ctl_type ctl,
   output ash_pkg::div_sts_type sts
);

   logic [ash_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [ash_pkg::SAMPLE_W-1:0]  rem_ff, rem_in;
   logic [ash_pkg::SAMPLE_W-1:0]  dvs_ff, dvs_in;
   logic [ash_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [ash_pkg::SAMPLE_W:0]    trial;

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[ash_pkg::DIV_W-1]};
      if (ctl.start) begin
         cnt_in  = ash_pkg::DIV_CNT_W'(ash_pkg::DIV_W);
         busy_in = 1'b1;
         rem_in  = '0;
         dvs_in  = ctl.divisor;
         quo_in  = ctl.dividend;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the trial fits one extra bit
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = ash_pkg::SAMPLE_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[ash_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[ash_pkg::SAMPLE_W-1:0];
            quo_in = {quo_ff[ash_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - ash_pkg::DIV_CNT_W'(1);
         if (cnt_ff == ash_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;

   typedef struct {
      logic [ash_pkg::PCT_W-1:0]    percent;
      logic [ash_pkg::SAMPLE_W-1:0] held_raw;
      logic                         line_fault;
   } reading_type;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          csr_we    = 1'b0;
   logic [ash_pkg::CSR_IDX_W-1:0] csr_index = ash_pkg::CSR_RANGE_LOW;
   logic [ash_pkg::SAMPLE_W-1:0]  csr_wdata = '0;

   ash_req_if req_ch ();
   ash_rsp_if rsp_ch ();

   averaged_sensor_with_hysteresis dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch)
   );

   always #6 clock = ~clock;

   // shadow of the block: group accumulator, held level and registers
   int unsigned acc_sum    = 0;
   int unsigned acc_count  = 0;
   int unsigned held_level = 0;
   int unsigned cfg_low    = 32'(ash_pkg::RANGE_LOW_RST);
   int unsigned cfg_high   = 32'(ash_pkg::RANGE_HIGH_RST);
   int unsigned cfg_band   = 32'(ash_pkg::HOLD_BAND_RST);
   int unsigned cfg_invert = 0;

   logic [ash_pkg::SAMPLE_W-1:0] sample_queue[$];
   reading_type                  expected_readings[$];
   bit                           mismatch_seen = 1'b0;

   // traffic shaping, set per phase by the stimulus block
   int       burst_left    = 1;
   int       gap_left      = 0;
   bit       sender_idles  = 1'b0;
   int       stall_mode    = 0;
   int       stall_left    = 0;
   logic [7:0] stall_pattern = 8'hFF;

   function automatic void absorb_sample(input logic [ash_pkg::SAMPLE_W-1:0] s);
      int unsigned avg, diff, x, pct;
      reading_type r;
      acc_sum   += 32'(s);
      acc_count += 1;
      if (acc_count < 32'(ash_pkg::GROUP_SIZE)) return;
      avg       = acc_sum / 32'(ash_pkg::GROUP_SIZE);
      acc_sum   = 0;
      acc_count = 0;
      diff = (avg >= held_level) ? avg - held_level : held_level - avg;
      if (diff > cfg_band) held_level = avg;
      pct = 0;
      // empty or inverted range reads as zero
      if (cfg_high > cfg_low) begin
         x = (held_level < cfg_low) ? cfg_low :
             (held_level > cfg_high) ? cfg_high : held_level;
         pct = ((x - cfg_low) * 32'(ash_pkg::SCALE_TOP)) / (cfg_high - cfg_low);
         if (cfg_invert != 0) pct = 32'(ash_pkg::SCALE_TOP) - pct;
      end
      r.percent    = ash_pkg::PCT_W'(pct);
      r.held_raw   = ash_pkg::SAMPLE_W'(held_level);
      r.line_fault = (held_level <= 32'(ash_pkg::FAULT_LEVEL));
      expected_readings.push_back(r);
   endfunction

   function automatic logic [ash_pkg::SAMPLE_W-1:0] clip10(input int v);
      if (v < 0) return '0;
      if (v > 1023) return '1;
      return ash_pkg::SAMPLE_W'(v);
   endfunction

   always @(posedge clock) begin : sample_driver
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_ch.valid  <= 1'b1;
            req_ch.sample <= sample_queue.pop_front();
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = int'($urandom_range(1, 12));
               gap_left   = sender_idles ? int'($urandom_range(1, 8)) : 0;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : sample_monitor
      if (!reset && req_ch.valid && req_ch.ready) absorb_sample(req_ch.sample);
   end

   always @(posedge clock) begin : result_stall
      logic go;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         go = 1'b1;
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            go = 1'b0;
         end else begin
            case (stall_mode)
               1: if ($urandom_range(0, 1) == 1) stall_left = int'($urandom_range(1, 3));
               2: if ($urandom_range(0, 7) == 0) stall_left = int'($urandom_range(5, 40));
               3: begin
                  go = stall_pattern[0];
                  stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
               end
               default: ;
            endcase
         end
         rsp_ch.ready <= go;
      end
   end

   always @(posedge clock) begin : result_check
      reading_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %0d/%0d/%0b",
                     $time, rsp_ch.percent, rsp_ch.held_raw, rsp_ch.line_fault);
            mismatch_seen = 1'b1;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_ch.percent !== want.percent) begin
               $display("%0t: percent expected %0d got %0d",
                        $time, want.percent, rsp_ch.percent);
               mismatch_seen = 1'b1;
            end
            if (rsp_ch.held_raw !== want.held_raw) begin
               $display("%0t: held_raw expected %0d got %0d",
                        $time, want.held_raw, rsp_ch.held_raw);
               mismatch_seen = 1'b1;
            end
            if (rsp_ch.line_fault !== want.line_fault) begin
               $display("%0t: line_fault expected %0b got %0b",
                        $time, want.line_fault, rsp_ch.line_fault);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   task automatic wait_sender_idle();
      @(negedge clock);
      while (sample_queue.size() != 0 || req_ch.valid) @(negedge clock);
   endtask

   // drain everything and wait until every expected reading is checked, then let the clock run on
   task automatic settle();
      wait_sender_idle();
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input ash_pkg::csr_index_type idx,
                            input logic [ash_pkg::SAMPLE_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         ash_pkg::CSR_RANGE_LOW:    cfg_low    = 32'(data);
         ash_pkg::CSR_RANGE_HIGH:   cfg_high   = 32'(data);
         ash_pkg::CSR_HOLD_BAND:    cfg_band   = 32'(data);
         ash_pkg::CSR_INVERT_SCALE: cfg_invert = 32'(data[0]);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_regs(input int lo, input int hi, input int band, input int inv);
      write_reg(ash_pkg::CSR_RANGE_LOW, ash_pkg::SAMPLE_W'(lo));
      write_reg(ash_pkg::CSR_RANGE_HIGH, ash_pkg::SAMPLE_W'(hi));
      write_reg(ash_pkg::CSR_HOLD_BAND, ash_pkg::SAMPLE_W'(band));
      write_reg(ash_pkg::CSR_INVERT_SCALE, ash_pkg::SAMPLE_W'(inv));
   endtask

   // fills the rest of the current group (or up to limit) around a chosen level or with uniform random samples
   task automatic queue_group(input int limit, output int pushed);
      int n, kind, base, spread, sgn;
      wait_sender_idle();
      n = ash_pkg::GROUP_SIZE - int'(acc_count);
      if (n > limit) n = limit;
      kind   = int'($urandom_range(0, 11));
      sgn    = ($urandom_range(0, 1) == 1) ? 1 : -1;
      spread = 0;
      case (kind)
         0: base = -1;
         1: base = int'(held_level) + sgn * int'(cfg_band);
         2: base = int'(held_level) + sgn * (int'(cfg_band) + 1);
         3: begin
            base   = int'($urandom_range(0, 14));
            spread = int'($urandom_range(0, 3));
         end
         4: base = ($urandom_range(0, 1) == 1) ? 1023 : 0;
         5: begin
            base   = int'(held_level) + sgn * int'($urandom_range(0, 2 * cfg_band + 2));
            spread = int'($urandom_range(0, 5));
         end
         default: begin
            base   = int'($urandom_range(0, 1023));
            spread = int'($urandom_range(0, 40));
         end
      endcase
      for (int i = 0; i < n; i++) begin
         if (base < 0) begin
            sample_queue.push_back(ash_pkg::SAMPLE_W'($urandom_range(0, 1023)));
         end else begin
            sample_queue.push_back(clip10(base + int'($urandom_range(0, 2 * spread)) - spread));
         end
      end
      pushed = n;
   endtask

   initial begin : stimulus
      int total, phase, target, phase_items, got;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      rsp_ch.ready  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: a group of zeros stays at zero and flags a line fault
      for (int i = 0; i < ash_pkg::GROUP_SIZE; i++) sample_queue.push_back('0);
      settle();
      // full-scale samples with an empty range written in the middle of the group;
      // upper invert bits must be ignored
      for (int i = 0; i < 7; i++) sample_queue.push_back('1);
      settle();
      write_reg(ash_pkg::CSR_RANGE_HIGH, '0);
      write_reg(ash_pkg::CSR_INVERT_SCALE, '1);
      for (int i = 0; i < ash_pkg::GROUP_SIZE - 7; i++) sample_queue.push_back('1);

      total = 0;
      phase = 0;
      while (total < 1950) begin
         settle();
         case (phase)
            0: program_regs(0, 1023, 0, 0);
            1: program_regs(1023, 0, 1023, 1);
            2: program_regs(300, 300, 5, 0);
            3: program_regs(0, 1, 1, 1);
            4: program_regs(1022, 1023, 0, 'h3FE);
            default: begin
               target = int'($urandom_range(0, 1023));
               program_regs(target,
                            ($urandom_range(0, 3) != 0) ? int'($urandom_range(target, 1023))
                                                        : int'($urandom_range(0, 1023)),
                            ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 40))
                                                        : int'($urandom_range(0, 1023)),
                            int'($urandom_range(0, 1023)));
            end
         endcase
         stall_mode    = int'($urandom_range(0, 3));
         stall_pattern = 8'($urandom_range(1, 255));
         sender_idles  = ($urandom_range(0, 3) != 0);
         // phase lengths are rarely a multiple of the group size
         target      = int'($urandom_range(90, 230));
         phase_items = 0;
         while (phase_items < target) begin
            queue_group(target - phase_items, got);
            phase_items += got;
         end
         total += target;
         phase++;
      end
      settle();

      if (mismatch_seen || expected_readings.size() != 0)
         $display("Mismatches found");
      else
         $display("No mismatches found");
      $finish;
   end

   initial begin : watchdog
      #6000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
